// ===== src/smbsw_pkg.sv =====
`timescale 1ns / 1ps

package smbsw_pkg;

    localparam int unsigned DEF_MAX_TABLE_BYTES = 65536;
    localparam logic [7:0]  EOT_TYPE            = 8'd127;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    localparam logic [2:0] ADDR_QUERY_TYPE  = 3'd0;
    localparam logic [2:0] ADDR_QUERY_INDEX = 3'd4;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_BODY = 2'd1,
        PH_STOP = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        STOP_BOUNDARY = 2'd0,
        STOP_EOT      = 2'd1,
        STOP_MALFORM  = 2'd2,
        STOP_WRAP     = 2'd3
    } t_stop;

    typedef enum logic {
        KIND_REPORT  = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       record_kind;
        logic [7:0]  struct_type;
        logic [15:0] struct_offset;
        logic [15:0] struct_length;
        logic        is_requested;
        logic [15:0] type_count;
        logic        found;
        logic [15:0] found_offset;
        logic [15:0] found_length;
        t_stop       stop_cause;
        logic        last;
    } t_result;

endpackage

// ===== src/smbios_structure_walker.sv =====
`timescale 1ns / 1ps

// channel   | direction | handshake                       | payload
// s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready | one table byte, tlast = table end
// m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready | structure report or summary
// apb       | in        | psel/penable/pwrite, pready = 1 | query_type @0, query_index @4
//
// one byte is taken per cycle while o_s_axis_tready is high; each byte is decoded
// in the cycle it is taken and its one or two results go into a four-entry result queue
// the result queue drains one result per cycle while i_m_axis_tready is high, so
// a byte causing both a report and a summary fills two queue entries; tready drops
// while fewer than two queue entries are free
// reset (synchronous, active low) clears the walk state and the queue and
// sets query_type to 0 and query_index to 1

module smbios_structure_walker
    import smbsw_pkg::*;
#(
    parameter int unsigned MAX_TABLE_BYTES = DEF_MAX_TABLE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tlast,   // table_end

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // struct_type, struct_offset, struct_length, is_requested, type_count,
    // found, found_offset, found_length, stop_cause, zero fill
    output logic [95:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser,   // record_kind
    output logic        o_m_axis_tlast,   // last

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned POS_W = $clog2(MAX_TABLE_BYTES);

    logic [7:0]  r_query_type;
    logic [15:0] r_query_index;

    t_phase      r_phase,      n_phase;
    logic [15:0] r_bis,        n_bis;
    logic [7:0]  r_flen,       n_flen;
    logic [7:0]  r_ctype,      n_ctype;
    logic [POS_W-1:0] r_start, n_start;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic        r_prev_zero,  n_prev_zero;
    logic [15:0] r_match,      n_match;
    logic        r_found,      n_found;
    logic [POS_W-1:0] r_fstart, n_fstart;
    logic [15:0] r_fsize,      n_fsize;
    t_stop       r_stop,       n_stop;

    t_result     r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [FIFO_AW:0]   r_count;

    logic        s_fire, m_fire, cfg_wr;
    logic        endm, closed;
    logic [15:0] p;
    logic [16:0] len_full;
    logic [15:0] len;
    logic [15:0] match_inc;
    logic        req;
    t_result     rep, summ;
    logic [1:0]  nwr;
    t_result     wr0, wr1;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (paddr)
            ADDR_QUERY_TYPE:  prdata = {24'd0, r_query_type};
            ADDR_QUERY_INDEX: prdata = {16'd0, r_query_index};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_type  <= 8'd0;
            r_query_index <= 16'd1;
        end else if (cfg_wr) begin
            if (paddr == ADDR_QUERY_TYPE)
                r_query_type <= pwdata[7:0];
            if (paddr == ADDR_QUERY_INDEX)
                r_query_index <= pwdata[15:0];
        end
    end

    assign o_s_axis_tready = (r_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign s_fire = i_s_axis_tvalid & o_s_axis_tready;
    assign o_m_axis_tvalid = (r_count != '0);
    assign m_fire = o_m_axis_tvalid & i_m_axis_tready;

    assign endm = i_s_axis_tlast |
                  (({1'b0, r_pos} + (POS_W+1)'(1)) >= (POS_W+1)'(MAX_TABLE_BYTES));
    assign p = r_bis;

    always_comb begin
        n_phase     = r_phase;
        n_bis       = r_bis;
        n_flen      = r_flen;
        n_ctype     = r_ctype;
        n_start     = r_start;
        n_prev_zero = r_prev_zero;
        n_match     = r_match;
        n_found     = r_found;
        n_fstart    = r_fstart;
        n_fsize     = r_fsize;
        n_stop      = r_stop;
        closed      = 1'b0;
        req         = 1'b0;
        len_full    = {1'b0, p} + 17'd1;
        len         = len_full[16] ? 16'hFFFF : len_full[15:0];
        match_inc   = r_match + 16'd1;

        if (r_phase != PH_STOP) begin
            if (p == 16'd0) begin
                n_ctype = i_s_axis_tdata;
                n_start = r_pos;
            end
            if (p == 16'd1)
                n_flen = i_s_axis_tdata;

            if (p == 16'd3 && n_flen < 8'd4) begin
                n_phase = PH_STOP;
                n_stop  = STOP_MALFORM;
            end else if (p >= 16'd3) begin
                n_phase = PH_BODY;
                if (p >= 16'd4 && p > {8'd0, n_flen} && i_s_axis_tdata == 8'd0 && r_prev_zero)
                    closed = 1'b1;
                else
                    n_prev_zero = (p >= {8'd0, n_flen}) && (i_s_axis_tdata == 8'd0);
            end

            if (closed) begin
                if (n_ctype == r_query_type) begin
                    if (r_query_index != 16'd0 && match_inc == r_query_index && !r_found) begin
                        req      = 1'b1;
                        n_found  = 1'b1;
                        n_fstart = n_start;
                        n_fsize  = len;
                    end
                    n_match = match_inc;
                end
                n_bis       = 16'd0;
                n_prev_zero = 1'b0;
                n_flen      = 8'd0;
                n_phase     = PH_HEAD;
                if (n_ctype == r_query_type && n_match == 16'd0) begin
                    n_phase = PH_STOP;
                    n_stop  = STOP_WRAP;
                end else if (n_ctype == EOT_TYPE) begin
                    n_phase = PH_STOP;
                    n_stop  = STOP_EOT;
                end
            end else if (n_phase != PH_STOP) begin
                n_bis = p + 16'd1;
                if (endm && p >= 16'd3) begin
                    n_phase = PH_STOP;
                    n_stop  = STOP_MALFORM;
                end
            end
        end

        n_pos = r_pos + POS_W'(1);

        rep               = '0;
        rep.record_kind   = KIND_REPORT;
        rep.struct_type   = n_ctype;
        rep.struct_offset = 16'(n_start);
        rep.struct_length = len;
        rep.is_requested  = req;
        rep.type_count    = n_match;
        rep.last          = !endm;

        summ              = '0;
        summ.record_kind  = KIND_SUMMARY;
        summ.type_count   = n_match;
        summ.found        = n_found;
        summ.found_offset = n_found ? 16'(n_fstart) : 16'd0;
        summ.found_length = n_found ? n_fsize : 16'd0;
        summ.stop_cause   = n_stop;
        summ.last         = 1'b1;

        if (endm) begin
            n_phase     = PH_HEAD;
            n_bis       = 16'd0;
            n_flen      = 8'd0;
            n_ctype     = 8'd0;
            n_start     = '0;
            n_pos       = '0;
            n_prev_zero = 1'b0;
            n_match     = 16'd0;
            n_found     = 1'b0;
            n_fstart    = '0;
            n_fsize     = 16'd0;
            n_stop      = STOP_BOUNDARY;
        end

        wr0 = closed ? rep : summ;
        wr1 = summ;
        if (!s_fire)
            nwr = 2'd0;
        else if (closed && endm)
            nwr = 2'd2;
        else if (closed || endm)
            nwr = 2'd1;
        else
            nwr = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEAD;
            r_bis       <= 16'd0;
            r_flen      <= 8'd0;
            r_ctype     <= 8'd0;
            r_start     <= '0;
            r_pos       <= '0;
            r_prev_zero <= 1'b0;
            r_match     <= 16'd0;
            r_found     <= 1'b0;
            r_fstart    <= '0;
            r_fsize     <= 16'd0;
            r_stop      <= STOP_BOUNDARY;
        end else if (s_fire) begin
            r_phase     <= n_phase;
            r_bis       <= n_bis;
            r_flen      <= n_flen;
            r_ctype     <= n_ctype;
            r_start     <= n_start;
            r_pos       <= n_pos;
            r_prev_zero <= n_prev_zero;
            r_match     <= n_match;
            r_found     <= n_found;
            r_fstart    <= n_fstart;
            r_fsize     <= n_fsize;
            r_stop      <= n_stop;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (nwr != 2'd0)
            r_fifo[r_wptr] <= wr0;
        if (nwr == 2'd2)
            r_fifo[r_wptr + FIFO_AW'(1)] <= wr1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + FIFO_AW'(nwr);
            if (m_fire)
                r_rptr <= r_rptr + FIFO_AW'(1);
            r_count <= r_count + (FIFO_AW+1)'(nwr) - (FIFO_AW+1)'(m_fire);
        end
    end

    t_result head;
    assign head = r_fifo[r_rptr];

    assign o_m_axis_tdata = {4'd0,
                             head.stop_cause,
                             head.found_length,
                             head.found_offset,
                             head.found,
                             head.type_count,
                             head.is_requested,
                             head.struct_length,
                             head.struct_offset,
                             head.struct_type};
    assign o_m_axis_tuser = head.record_kind;
    assign o_m_axis_tlast = head.last;

endmodule
